[src/rpb_pkg.sv]
// shared constants and types for the rgb pixel blender
`timescale 1ns / 1ps

package rpb_pkg;

    // channel width and full-scale value
    localparam int CHAN_W = 8;
    localparam logic [CHAN_W-1:0] CH_MAX = {CHAN_W{1'b1}};

    // opacity in q1.8, one is 256
    localparam int OPA_W = 9;
    localparam int OPA_SHIFT = 8;
    localparam logic [OPA_W-1:0] OPA_ONE = OPA_W'(256);

    // configuration port
    localparam int CFG_W = OPA_W;
    typedef logic [0:0] t_reg_idx;
    localparam t_reg_idx REG_MODE          = 1'b0;
    localparam t_reg_idx REG_LAYER_OPACITY = 1'b1;

    // blend mode codes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_OVERWRITE = 2'd0;
    localparam t_mode MODE_ADD       = 2'd1;
    localparam t_mode MODE_MULTIPLY  = 2'd2;
    localparam t_mode MODE_LERP      = 2'd3;

    typedef logic [OPA_W-1:0] t_opa;

    // stage enables and settings shared by the three lanes
    typedef struct packed {
        logic  en1;
        logic  en2;
        logic  en3;
        t_mode mode;
        t_opa  opa_base;
        t_opa  opa_layer;
    } t_lane_ctrl;

endpackage

[src/rpb_in_if.sv]
// request channel carrying a base pixel and a layer pixel
`timescale 1ns / 1ps

interface rpb_in_if;
    import rpb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] base_red;
    logic [CHAN_W-1:0] base_green;
    logic [CHAN_W-1:0] base_blue;
    logic [CHAN_W-1:0] layer_red;
    logic [CHAN_W-1:0] layer_green;
    logic [CHAN_W-1:0] layer_blue;

    modport source (
        output valid, base_red, base_green, base_blue, layer_red, layer_green, layer_blue,
        input  ready
    );
    modport sink (
        input  valid, base_red, base_green, base_blue, layer_red, layer_green, layer_blue,
        output ready
    );
endinterface

[src/rpb_out_if.sv]
// request channel carrying one blended pixel
`timescale 1ns / 1ps

interface rpb_out_if;
    import rpb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_blue;

    modport source (
        output valid, out_red, out_green, out_blue,
        input  ready
    );
    modport sink (
        input  valid, out_red, out_green, out_blue,
        output ready
    );
endinterface

[src/rpb_lane.sv]
// three-stage datapath for one color channel
`timescale 1ns / 1ps

module rpb_lane (
    input  logic                       i_clk,
    input  rpb_pkg::t_lane_ctrl        i_ctrl,
    input  logic [rpb_pkg::CHAN_W-1:0] i_base,
    input  logic [rpb_pkg::CHAN_W-1:0] i_layer,
    output logic [rpb_pkg::CHAN_W-1:0] o_chan
);
    import rpb_pkg::*;

    localparam int PROD_W = 2 * CHAN_W;
    localparam int DIV_W  = PROD_W + 1;
    localparam int LERP_W = CHAN_W + OPA_W;

    // stage 1: captured operands
    logic [CHAN_W-1:0] r_a;
    logic [CHAN_W-1:0] r_b;

    // stage 2: products and saturated sum
    logic [PROD_W-1:0] r_mul;
    logic [LERP_W-1:0] r_pa;
    logic [LERP_W-1:0] r_pb;
    logic [CHAN_W-1:0] r_add;
    logic [CHAN_W-1:0] r_b2;

    // stage 3: result
    logic [CHAN_W-1:0] r_out;

    logic [CHAN_W:0]   n_sum;
    logic [CHAN_W-1:0] n_add;
    logic [DIV_W-1:0]  n_div;
    logic [LERP_W-1:0] n_lerp;
    logic [CHAN_W-1:0] n_out;

    // stage 1 capture
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en1) begin
            r_a <= i_base;
            r_b <= i_layer;
        end
    end

    // saturating add
    assign n_sum = {1'b0, r_a} + {1'b0, r_b};
    assign n_add = n_sum[CHAN_W] ? CH_MAX : n_sum[CHAN_W-1:0];

    // stage 2 multiplies
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en2) begin
            r_mul <= PROD_W'(r_a) * PROD_W'(r_b);
            r_pa  <= LERP_W'(r_a) * LERP_W'(i_ctrl.opa_base);
            r_pb  <= LERP_W'(r_b) * LERP_W'(i_ctrl.opa_layer);
            r_add <= n_add;
            r_b2  <= r_b;
        end
    end

    // divide by full scale: floor(p / m) = (p + (p >> w) + 1) >> w for p <= m*m
    assign n_div  = {1'b0, r_mul} + {1'b0, r_mul >> CHAN_W} + DIV_W'(1);
    assign n_lerp = r_pa + r_pb;

    // mode select
    always_comb begin
        unique case (i_ctrl.mode)
            MODE_OVERWRITE: n_out = r_b2;
            MODE_ADD:       n_out = r_add;
            MODE_MULTIPLY:  n_out = n_div[PROD_W-1:CHAN_W];
            MODE_LERP:      n_out = n_lerp[CHAN_W+OPA_SHIFT-1:OPA_SHIFT];
            default:        n_out = r_b2;
        endcase
    end

    // stage 3 output register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en3) begin
            r_out <= n_out;
        end
    end

    assign o_chan = r_out;

endmodule

[src/rgb_pixel_blend.sv]
// Blends a base RGB pixel with a layer RGB pixel, channel by channel, using the
// mode in the mode register: overwrite, saturating add, multiply scaled by
// 1/255, or linear interpolation weighted by layer_opacity (q1.8, values above
// 256 count as 256). The block takes one pixel per clock while the output is
// not stalled; three register stages (capture, multiply, select) carry a valid
// bit each, and i_pix.ready only drops when every stage is full and the output
// request is not being taken. Write configuration only while no pixel is in
// flight.
`timescale 1ns / 1ps

module rgb_pixel_blend (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    rpb_in_if.sink                     i_pix,
    rpb_out_if.source                  o_pix,
    input  logic                       i_cfg_we,
    input  rpb_pkg::t_reg_idx          i_cfg_idx,
    input  logic [rpb_pkg::CFG_W-1:0]  i_cfg_wdata
);
    import rpb_pkg::*;

    logic       r_v1;
    logic       r_v2;
    logic       r_v3;
    t_mode      r_mode;
    t_opa       r_layer_opacity;

    logic       en1;
    logic       en2;
    logic       en3;
    t_opa       opa_sat;
    t_lane_ctrl lane_ctrl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= MODE_OVERWRITE;
            r_layer_opacity <= OPA_ONE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_MODE:          r_mode          <= i_cfg_wdata[1:0];
                REG_LAYER_OPACITY: r_layer_opacity <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage advance: a stage loads when it is empty or its contents move on
    assign en3 = !r_v3 || o_pix.ready;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_pix.valid;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // opacity clamp and lane control
    assign opa_sat = (r_layer_opacity > OPA_ONE) ? OPA_ONE : r_layer_opacity;

    assign lane_ctrl.en1       = en1;
    assign lane_ctrl.en2       = en2;
    assign lane_ctrl.en3       = en3;
    assign lane_ctrl.mode      = r_mode;
    assign lane_ctrl.opa_layer = opa_sat;
    assign lane_ctrl.opa_base  = OPA_ONE - opa_sat;

    // one lane per channel
    rpb_lane u_lane_red (
        .i_clk   (i_clk),
        .i_ctrl  (lane_ctrl),
        .i_base  (i_pix.base_red),
        .i_layer (i_pix.layer_red),
        .o_chan  (o_pix.out_red)
    );

    rpb_lane u_lane_green (
        .i_clk   (i_clk),
        .i_ctrl  (lane_ctrl),
        .i_base  (i_pix.base_green),
        .i_layer (i_pix.layer_green),
        .o_chan  (o_pix.out_green)
    );

    rpb_lane u_lane_blue (
        .i_clk   (i_clk),
        .i_ctrl  (lane_ctrl),
        .i_base  (i_pix.base_blue),
        .i_layer (i_pix.layer_blue),
        .o_chan  (o_pix.out_blue)
    );

    // handshake outputs
    assign i_pix.ready = en1;
    assign o_pix.valid = r_v3;

endmodule

[src/rpb_checker.sv]
// port-level checks for the pixel blender, bound to the top level
`timescale 1ns / 1ps

module rpb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [rpb_pkg::CHAN_W-1:0] i_out_red
);
    import rpb_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result request after reset");

    // input is only held off by a stalled output
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_out_valid || i_out_ready) |-> i_in_ready)
        else $error("input stalled while output is free");

    // a request accepted while the output stays free reaches the output
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_out_ready) ##1 i_out_ready ##1 i_out_ready
        |=> i_out_valid)
        else $error("result missing after three cycles");

    // a stalled result request holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_out_red)))
        else $error("stalled result dropped or changed");

endmodule

bind rgb_pixel_blend rpb_checker u_rpb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_pix.valid),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_red   (o_pix.out_red)
);

[tb/sv/rgb_pixel_blend_tb.sv]
// self-checking testbench for the rgb pixel blender
`timescale 1ns / 1ps

module rgb_pixel_blend_tb;
    import rpb_pkg::*;

    localparam int PIPE_LAT   = 3;
    localparam int RAND_SETS  = 10;
    localparam int SET_ITEMS  = 85;
    localparam int CALM_SET   = 5;
    localparam int IDLE_PCT   = 11;

    typedef logic [CHAN_W-1:0] t_chan;

    // one blend request: base pixel and layer pixel
    typedef struct packed {
        t_chan base_red;
        t_chan base_green;
        t_chan base_blue;
        t_chan layer_red;
        t_chan layer_green;
        t_chan layer_blue;
    } t_pix_pair;

    // one blended pixel
    typedef struct packed {
        t_chan red;
        t_chan green;
        t_chan blue;
    } t_rgb;

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    t_reg_idx            cfg_idx;
    logic [CFG_W-1:0]    cfg_wdata;

    rpb_in_if  pix_in();
    rpb_out_if pix_out();

    rgb_pixel_blend dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix       (pix_in),
        .o_pix       (pix_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // requests waiting to be driven and blended pixels still owed by the block
    t_pix_pair pair_q[$];
    t_rgb      blend_q[$];

    // local copy of the blend registers
    t_mode mode_cfg;
    t_opa  opa_cfg;

    logic  in_taken;
    logic  calm;
    int    fail_cnt;

    // clock
    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // blend one channel under the current register settings
    function automatic t_chan blend_chan(input t_chan a, input t_chan b);
        int sum;
        int wt;
        case (mode_cfg)
            MODE_OVERWRITE: return b;
            MODE_ADD: begin
                sum = int'(a) + int'(b);
                return (sum > int'(CH_MAX)) ? CH_MAX : t_chan'(sum);
            end
            MODE_MULTIPLY: return t_chan'((int'(a) * int'(b)) / int'(CH_MAX));
            default: begin
                // opacity above one counts as one
                wt = (opa_cfg > OPA_ONE) ? int'(OPA_ONE) : int'(opa_cfg);
                return t_chan'((int'(a) * (int'(OPA_ONE) - wt) + int'(b) * wt) >> OPA_SHIFT);
            end
        endcase
    endfunction

    function automatic t_rgb blend_pixel(input t_pix_pair p);
        t_rgb r;
        r.red   = blend_chan(p.base_red, p.layer_red);
        r.green = blend_chan(p.base_green, p.layer_green);
        r.blue  = blend_chan(p.base_blue, p.layer_blue);
        return r;
    endfunction

    function automatic void check_chan(input string name, input t_chan want, input t_chan got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_cnt++;
        end
    endfunction

    // channel value with a bias toward the extremes
    function automatic t_chan rand_chan();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return CH_MAX;
            default: return t_chan'($urandom);
        endcase
    endfunction

    // request driver, inputs change on the falling edge
    always @(negedge i_clk) begin : drv
        t_pix_pair nxt;
        logic      go;
        if (!i_rst_n) begin
            pix_in.valid  <= 1'b0;
            pix_out.ready <= 1'b0;
        end else begin
            if (!pix_in.valid || in_taken) begin
                go = pair_q.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT);
                if (go) begin
                    nxt = pair_q.pop_front();
                    pix_in.valid       <= 1'b1;
                    pix_in.base_red    <= nxt.base_red;
                    pix_in.base_green  <= nxt.base_green;
                    pix_in.base_blue   <= nxt.base_blue;
                    pix_in.layer_red   <= nxt.layer_red;
                    pix_in.layer_green <= nxt.layer_green;
                    pix_in.layer_blue  <= nxt.layer_blue;
                end else begin
                    pix_in.valid <= 1'b0;
                end
            end
            pix_out.ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
        end
    end

    // monitor: check results against the oldest prediction, then predict new requests
    always @(posedge i_clk) begin : mon
        t_rgb      want;
        t_pix_pair got_req;
        if (!i_rst_n) begin
            in_taken <= 1'b0;
        end else begin
            in_taken <= pix_in.valid && pix_in.ready;
            if (pix_out.valid && pix_out.ready) begin
                if (blend_q.size() == 0) begin
                    $error("blended pixel with no request outstanding");
                    fail_cnt++;
                end else begin
                    want = blend_q.pop_front();
                    check_chan("out_red", want.red, pix_out.out_red);
                    check_chan("out_green", want.green, pix_out.out_green);
                    check_chan("out_blue", want.blue, pix_out.out_blue);
                end
            end
            if (pix_in.valid && pix_in.ready) begin
                got_req = {pix_in.base_red, pix_in.base_green, pix_in.base_blue,
                           pix_in.layer_red, pix_in.layer_green, pix_in.layer_blue};
                blend_q.push_back(blend_pixel(got_req));
            end
        end
    end

    // register write, only while the pipe is empty
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= val;
        @(negedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_MODE)
            mode_cfg = t_mode'(val[1:0]);
        else
            opa_cfg = t_opa'(val);
    endtask

    // mode write carries random upper bits, which the block drops
    task automatic apply_setting(input t_mode m, input t_opa o);
        logic [CFG_W-1:0] w;
        w = CFG_W'($urandom);
        w[1:0] = m;
        write_reg(REG_MODE, w);
        write_reg(REG_LAYER_OPACITY, o);
    endtask

    // sender holds off until every blended pixel is back and the pipe is empty
    task automatic wait_drain();
        while (pair_q.size() != 0 || pix_in.valid || blend_q.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic push_pair(input t_chan br, input t_chan bg, input t_chan bb,
                             input t_chan lr, input t_chan lg, input t_chan lb);
        t_pix_pair p;
        p = {br, bg, bb, lr, lg, lb};
        pair_q.push_back(p);
    endtask

    // corner pixels: all zero, all full, mixed extremes, alternating bits
    task automatic run_corners();
        push_pair(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
        push_pair(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
        push_pair(8'hFF, 8'h00, 8'h80, 8'h00, 8'hFF, 8'hC8);
        push_pair(8'hAA, 8'h55, 8'h0F, 8'h55, 8'hAA, 8'hF0);
        wait_drain();
    endtask

    // pick an opacity, mostly around the edges of the q1.8 range
    function automatic t_opa pick_opa();
        case ($urandom_range(0, 8))
            0:       return t_opa'(0);
            1:       return t_opa'(1);
            2:       return t_opa'(255);
            3:       return OPA_ONE;
            4:       return t_opa'(257);
            5:       return t_opa'(511);
            default: return t_opa'($urandom_range(0, 511));
        endcase
    endfunction

    // stimulus
    initial begin : stim
        t_mode m;
        t_opa  o;
        i_rst_n       = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = REG_MODE;
        cfg_wdata     = '0;
        pix_in.valid  = 1'b0;
        pix_in.base_red    = '0;
        pix_in.base_green  = '0;
        pix_in.base_blue   = '0;
        pix_in.layer_red   = '0;
        pix_in.layer_green = '0;
        pix_in.layer_blue  = '0;
        pix_out.ready = 1'b0;
        in_taken      = 1'b0;
        calm          = 1'b0;
        fail_cnt      = 0;
        mode_cfg      = MODE_OVERWRITE;
        opa_cfg       = OPA_ONE;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset defaults, every mode, opacity zero and above one
        run_corners();
        apply_setting(MODE_ADD, OPA_ONE);
        run_corners();
        apply_setting(MODE_MULTIPLY, OPA_ONE);
        run_corners();
        apply_setting(MODE_LERP, OPA_ONE);
        run_corners();
        apply_setting(MODE_LERP, t_opa'(0));
        run_corners();
        apply_setting(MODE_LERP, t_opa'(300));
        run_corners();

        // random: each mode twice, then free picks, one set without idling
        for (int s = 0; s < RAND_SETS; s++) begin
            m = (s < 8) ? t_mode'(s % 4) : t_mode'($urandom_range(0, 3));
            if (s == 3)
                o = t_opa'(511);
            else if (s == 7)
                o = t_opa'(0);
            else
                o = pick_opa();
            apply_setting(m, o);
            calm = (s == CALM_SET);
            for (int k = 0; k < SET_ITEMS; k++)
                push_pair(rand_chan(), rand_chan(), rand_chan(),
                          rand_chan(), rand_chan(), rand_chan());
            wait_drain();
            calm = 1'b0;
        end

        repeat (PIPE_LAT + 5) @(posedge i_clk);
        if (fail_cnt == 0 && blend_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
